>>> design/tsfs_pkg.sv
// ----------------------------------------------------------------------------
// tsfs_pkg
// Shared types and constants of the touch sample filter and scaler.
// ----------------------------------------------------------------------------
package tsfs_pkg;

  localparam int unsigned SAMPLE_W  = 13;
  localparam int unsigned PIXEL_W   = 10;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 13;
  localparam int unsigned EVENT_W   = 2;

  // product of a 13-bit distance and a 10-bit pixel count
  localparam int unsigned PROD_W    = SAMPLE_W + PIXEL_W;
  // one quotient bit per divider step
  localparam int unsigned DIV_STEPS = PROD_W;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam logic [SAMPLE_W-1:0] X_OFFSET_RST     = SAMPLE_W'(200);
  localparam logic [SAMPLE_W-1:0] X_SPAN_RST       = SAMPLE_W'(3800);
  localparam logic [PIXEL_W-1:0]  X_PIXELS_RST     = PIXEL_W'(240);
  localparam logic [SAMPLE_W-1:0] Y_OFFSET_RST     = SAMPLE_W'(190);
  localparam logic [SAMPLE_W-1:0] Y_SPAN_RST       = SAMPLE_W'(3810);
  localparam logic [PIXEL_W-1:0]  Y_PIXELS_RST     = PIXEL_W'(320);
  localparam logic [SAMPLE_W-1:0] SPREAD_LIMIT_RST = SAMPLE_W'(25);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_OFFSET     = 3'd0,
    REG_X_SPAN       = 3'd1,
    REG_X_PIXELS     = 3'd2,
    REG_Y_OFFSET     = 3'd3,
    REG_Y_SPAN       = 3'd4,
    REG_Y_PIXELS     = 3'd5,
    REG_SPREAD_LIMIT = 3'd6
  } cfg_reg_e;

  typedef enum logic [EVENT_W-1:0] {
    EV_DOWN  = 2'd0,
    EV_UP    = 2'd1,
    EV_TOUCH = 2'd2
  } event_kind_e;

  typedef struct packed {
    logic [SAMPLE_W-1:0] x_offset;
    logic [SAMPLE_W-1:0] x_span;
    logic [PIXEL_W-1:0]  x_pixels;
    logic [SAMPLE_W-1:0] y_offset;
    logic [SAMPLE_W-1:0] y_span;
    logic [PIXEL_W-1:0]  y_pixels;
    logic [SAMPLE_W-1:0] spread_limit;
  } cfg_t;

  // one filtered event waiting for scaling
  typedef struct packed {
    logic [SAMPLE_W-1:0] x_avg;
    logic                x_ok;
    logic [SAMPLE_W-1:0] y_avg;
    logic                released;
  } entry_t;

endpackage

>>> design/tsfs_front.sv
// ----------------------------------------------------------------------------
// tsfs_front
// Accepts touch events, picks the middle two samples per axis, averages them
// and checks the X spread; the filtered event is held in one stage register.
// ----------------------------------------------------------------------------
module tsfs_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tsfs_pkg::cfg_t                cfg_i,
  input  logic                          push_i,
  output logic                          full_o,
  input  logic [tsfs_pkg::SAMPLE_W-1:0] x_sample_a_i,
  input  logic [tsfs_pkg::SAMPLE_W-1:0] x_sample_b_i,
  input  logic [tsfs_pkg::SAMPLE_W-1:0] x_sample_c_i,
  input  logic [tsfs_pkg::SAMPLE_W-1:0] x_sample_d_i,
  input  logic [tsfs_pkg::SAMPLE_W-1:0] y_sample_a_i,
  input  logic [tsfs_pkg::SAMPLE_W-1:0] y_sample_b_i,
  input  logic [tsfs_pkg::SAMPLE_W-1:0] y_sample_c_i,
  input  logic [tsfs_pkg::SAMPLE_W-1:0] y_sample_d_i,
  input  logic                          pen_released_i,
  output logic                          q_push_o,
  output tsfs_pkg::entry_t              q_entry_o,
  input  logic                          q_full_i
);
  import tsfs_pkg::*;

  logic                stage_valid_q, stage_valid_d;
  entry_t              stage_q, stage_d;
  logic                stage_free;
  logic                accept;
  logic [SAMPLE_W-1:0] x_hi, x_lo, y_hi, y_lo;
  logic [SAMPLE_W:0]   x_sum, y_sum;

  // middle two of four: the smaller of the pair maxima and the larger of the
  // pair minima
  function automatic logic [2*SAMPLE_W-1:0] mid_pair(
    input logic [SAMPLE_W-1:0] a,
    input logic [SAMPLE_W-1:0] b,
    input logic [SAMPLE_W-1:0] c,
    input logic [SAMPLE_W-1:0] d
  );
    logic [SAMPLE_W-1:0] h1, l1, h2, l2, m1, m2;
    h1 = (a > b) ? a : b;
    l1 = (a > b) ? b : a;
    h2 = (c > d) ? c : d;
    l2 = (c > d) ? d : c;
    m1 = (h1 < h2) ? h1 : h2;
    m2 = (l1 > l2) ? l1 : l2;
    mid_pair = (m1 > m2) ? {m1, m2} : {m2, m1};
  endfunction

  assign {x_hi, x_lo} = mid_pair(x_sample_a_i, x_sample_b_i, x_sample_c_i, x_sample_d_i);
  assign {y_hi, y_lo} = mid_pair(y_sample_a_i, y_sample_b_i, y_sample_c_i, y_sample_d_i);

  assign x_sum = {1'b0, x_hi} + {1'b0, x_lo};
  assign y_sum = {1'b0, y_hi} + {1'b0, y_lo};

  assign stage_free = !stage_valid_q || !q_full_i;
  assign full_o     = !stage_free;
  assign accept     = push_i && stage_free;
  assign q_push_o   = stage_valid_q;
  assign q_entry_o  = stage_q;

  always_comb begin
    stage_valid_d = stage_valid_q;
    stage_d       = stage_q;
    if (stage_valid_q && !q_full_i) begin
      stage_valid_d = 1'b0;
    end
    if (accept) begin
      stage_valid_d    = 1'b1;
      stage_d.x_avg    = x_sum[SAMPLE_W:1];
      stage_d.x_ok     = (x_hi - x_lo) <= cfg_i.spread_limit;
      stage_d.y_avg    = y_sum[SAMPLE_W:1];
      stage_d.released = pen_released_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else begin
      stage_valid_q <= stage_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stage_q <= stage_d;
  end

endmodule

>>> design/tsfs_queue.sv
// ----------------------------------------------------------------------------
// tsfs_queue
// Short queue of filtered events between the front end and the scaler.
// ----------------------------------------------------------------------------
module tsfs_queue #(
  parameter int unsigned DEPTH = tsfs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  tsfs_pkg::entry_t entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output tsfs_pkg::entry_t entry_o
);
  import tsfs_pkg::*;

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  entry_t             slots_q [DEPTH];
  logic [IDX_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]   count_q;
  logic               do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign entry_o = slots_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  function automatic logic [IDX_W-1:0] next_ptr(input logic [IDX_W-1:0] p);
    next_ptr = (p == IDX_W'(DEPTH - 1)) ? '0 : p + IDX_W'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

>>> design/tsfs_back.sv
// ----------------------------------------------------------------------------
// tsfs_back
// Scales both axes through a shared multiply step and one restoring divider
// per axis, updates the held coordinates and emits the touch events.
// ----------------------------------------------------------------------------
module tsfs_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tsfs_pkg::cfg_t               cfg_i,
  input  logic                         q_valid_i,
  input  tsfs_pkg::entry_t             q_entry_i,
  output logic                         q_pop_o,
  output logic                         empty_o,
  input  logic                         pop_i,
  output logic [tsfs_pkg::EVENT_W-1:0] event_kind_o,
  output logic [tsfs_pkg::PIXEL_W-1:0] x_pos_o,
  output logic [tsfs_pkg::PIXEL_W-1:0] y_pos_o,
  output logic                         last_of_run_o
);
  import tsfs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_FINISH,
    S_EMIT_FIRST,
    S_EMIT_LAST
  } state_e;

  state_e              state_q, state_d;
  entry_t              entry_q, entry_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic [PROD_W-1:0]   num_x_q, num_x_d, num_y_q, num_y_d;
  logic [PROD_W-1:0]   quo_x_q, quo_x_d, quo_y_q, quo_y_d;
  logic [SAMPLE_W-1:0] rem_x_q, rem_x_d, rem_y_q, rem_y_d;
  logic                ok_x_q, ok_x_d, ok_y_q, ok_y_d;
  logic [PIXEL_W-1:0]  held_x_q, held_x_d, held_y_q, held_y_d;
  logic                out_valid_q, out_valid_d;
  event_kind_e         out_kind_q, out_kind_d;
  logic [PIXEL_W-1:0]  out_x_q, out_x_d, out_y_q, out_y_d;
  logic                out_last_q, out_last_d;

  logic [SAMPLE_W-1:0] diff_x, diff_y;
  logic [PROD_W-1:0]   prod_x, prod_y;
  logic [SAMPLE_W:0]   sh_x, sh_y, sub_x, sub_y;
  logic                slot_free;

  assign diff_x = entry_q.x_avg - cfg_i.x_offset;
  assign diff_y = entry_q.y_avg - cfg_i.y_offset;
  assign prod_x = PROD_W'(diff_x) * PROD_W'(cfg_i.x_pixels);
  assign prod_y = PROD_W'(diff_y) * PROD_W'(cfg_i.y_pixels);

  // restoring division, one quotient bit per cycle
  assign sh_x  = {rem_x_q, num_x_q[PROD_W-1]};
  assign sh_y  = {rem_y_q, num_y_q[PROD_W-1]};
  assign sub_x = sh_x - {1'b0, cfg_i.x_span};
  assign sub_y = sh_y - {1'b0, cfg_i.y_span};

  assign slot_free = !out_valid_q || pop_i;

  always_comb begin
    state_d     = state_q;
    entry_d     = entry_q;
    step_d      = step_q;
    num_x_d     = num_x_q;
    num_y_d     = num_y_q;
    quo_x_d     = quo_x_q;
    quo_y_d     = quo_y_q;
    rem_x_d     = rem_x_q;
    rem_y_d     = rem_y_q;
    ok_x_d      = ok_x_q;
    ok_y_d      = ok_y_q;
    held_x_d    = held_x_q;
    held_y_d    = held_y_q;
    out_valid_d = out_valid_q;
    out_kind_d  = out_kind_q;
    out_x_d     = out_x_q;
    out_y_d     = out_y_q;
    out_last_d  = out_last_q;
    q_pop_o     = 1'b0;

    if (out_valid_q && pop_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          entry_d = q_entry_i;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        num_x_d = prod_x;
        num_y_d = prod_y;
        ok_x_d  = entry_q.x_ok && (cfg_i.x_span != '0) && (entry_q.x_avg >= cfg_i.x_offset);
        ok_y_d  = (cfg_i.y_span != '0) && (entry_q.y_avg >= cfg_i.y_offset);
        rem_x_d = '0;
        rem_y_d = '0;
        quo_x_d = '0;
        quo_y_d = '0;
        step_d  = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        num_x_d = {num_x_q[PROD_W-2:0], 1'b0};
        num_y_d = {num_y_q[PROD_W-2:0], 1'b0};
        if (!sub_x[SAMPLE_W]) begin
          rem_x_d = sub_x[SAMPLE_W-1:0];
          quo_x_d = {quo_x_q[PROD_W-2:0], 1'b1};
        end else begin
          rem_x_d = sh_x[SAMPLE_W-1:0];
          quo_x_d = {quo_x_q[PROD_W-2:0], 1'b0};
        end
        if (!sub_y[SAMPLE_W]) begin
          rem_y_d = sub_y[SAMPLE_W-1:0];
          quo_y_d = {quo_y_q[PROD_W-2:0], 1'b1};
        end else begin
          rem_y_d = sh_y[SAMPLE_W-1:0];
          quo_y_d = {quo_y_q[PROD_W-2:0], 1'b0};
        end
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_W'(DIV_STEPS - 1)) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        // zero or beyond the pixel count keeps the held coordinate
        if (ok_x_q && (quo_x_q != '0) && (quo_x_q <= PROD_W'(cfg_i.x_pixels))) begin
          held_x_d = quo_x_q[PIXEL_W-1:0];
        end
        if (ok_y_q && (quo_y_q != '0) && (quo_y_q <= PROD_W'(cfg_i.y_pixels))) begin
          held_y_d = quo_y_q[PIXEL_W-1:0];
        end
        state_d = S_EMIT_FIRST;
      end
      S_EMIT_FIRST: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = entry_q.released ? EV_UP : EV_DOWN;
          out_last_d  = !entry_q.released;
          out_x_d     = held_x_q;
          out_y_d     = held_y_q;
          state_d     = entry_q.released ? S_EMIT_LAST : S_IDLE;
        end
      end
      S_EMIT_LAST: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = EV_TOUCH;
          out_last_d  = 1'b1;
          out_x_d     = held_x_q;
          out_y_d     = held_y_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      held_x_q    <= '0;
      held_y_q    <= '0;
      out_valid_q <= 1'b0;
      out_kind_q  <= EV_DOWN;
      out_x_q     <= '0;
      out_y_q     <= '0;
      out_last_q  <= 1'b0;
      entry_q     <= '0;
      step_q      <= '0;
      num_x_q     <= '0;
      num_y_q     <= '0;
      quo_x_q     <= '0;
      quo_y_q     <= '0;
      rem_x_q     <= '0;
      rem_y_q     <= '0;
      ok_x_q      <= 1'b0;
      ok_y_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      held_x_q    <= held_x_d;
      held_y_q    <= held_y_d;
      out_valid_q <= out_valid_d;
      out_kind_q  <= out_kind_d;
      out_x_q     <= out_x_d;
      out_y_q     <= out_y_d;
      out_last_q  <= out_last_d;
      entry_q     <= entry_d;
      step_q      <= step_d;
      num_x_q     <= num_x_d;
      num_y_q     <= num_y_d;
      quo_x_q     <= quo_x_d;
      quo_y_q     <= quo_y_d;
      rem_x_q     <= rem_x_d;
      rem_y_q     <= rem_y_d;
      ok_x_q      <= ok_x_d;
      ok_y_q      <= ok_y_d;
    end
  end

  assign empty_o       = !out_valid_q;
  assign event_kind_o  = out_kind_q;
  assign x_pos_o       = out_x_q;
  assign y_pos_o       = out_y_q;
  assign last_of_run_o = out_last_q;

endmodule

>>> design/touch_sample_filter_scaler.sv
// ----------------------------------------------------------------------------
// touch_sample_filter_scaler
// Median filter and calibration of resistive touch samples.
// ----------------------------------------------------------------------------
// The front end takes one touch event per cycle into a single stage while
// it is not full, picks and averages the middle two samples per axis and
// checks the X spread. A queue of QUEUE_DEPTH events feeds the scaler, which
// handles one event at a time: it takes the event from the queue, multiplies,
// runs the restoring division (both axes in parallel), updates the held
// coordinates and then emits each result, waiting while the output is full.
// The divider sets the sustained rate. A press gives one touch-down
// result, a release a touch-up and then a touch result; both carry the held
// coordinates. Configuration registers are written through the cfg channel,
// which is always ready.
// ----------------------------------------------------------------------------
module touch_sample_filter_scaler #(
  parameter int unsigned QUEUE_DEPTH = tsfs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tsfs_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [tsfs_pkg::CFG_DAT_W-1:0] cfg_data_i,
  input  logic                           push_i,
  output logic                           full_o,
  input  logic [tsfs_pkg::SAMPLE_W-1:0]  x_sample_a_i,
  input  logic [tsfs_pkg::SAMPLE_W-1:0]  x_sample_b_i,
  input  logic [tsfs_pkg::SAMPLE_W-1:0]  x_sample_c_i,
  input  logic [tsfs_pkg::SAMPLE_W-1:0]  x_sample_d_i,
  input  logic [tsfs_pkg::SAMPLE_W-1:0]  y_sample_a_i,
  input  logic [tsfs_pkg::SAMPLE_W-1:0]  y_sample_b_i,
  input  logic [tsfs_pkg::SAMPLE_W-1:0]  y_sample_c_i,
  input  logic [tsfs_pkg::SAMPLE_W-1:0]  y_sample_d_i,
  input  logic                           pen_released_i,
  output logic                           empty_o,
  input  logic                           pop_i,
  output logic [tsfs_pkg::EVENT_W-1:0]   event_kind_o,
  output logic [tsfs_pkg::PIXEL_W-1:0]   x_pos_o,
  output logic [tsfs_pkg::PIXEL_W-1:0]   y_pos_o,
  output logic                           last_of_run_o
);
  import tsfs_pkg::*;

  cfg_t   cfg_q;
  logic   q_push, q_full, q_valid, q_pop;
  entry_t q_entry_in, q_entry_out;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_offset     <= X_OFFSET_RST;
      cfg_q.x_span       <= X_SPAN_RST;
      cfg_q.x_pixels     <= X_PIXELS_RST;
      cfg_q.y_offset     <= Y_OFFSET_RST;
      cfg_q.y_span       <= Y_SPAN_RST;
      cfg_q.y_pixels     <= Y_PIXELS_RST;
      cfg_q.spread_limit <= SPREAD_LIMIT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_X_OFFSET:     cfg_q.x_offset     <= cfg_data_i;
        REG_X_SPAN:       cfg_q.x_span       <= cfg_data_i;
        REG_X_PIXELS:     cfg_q.x_pixels     <= cfg_data_i[PIXEL_W-1:0];
        REG_Y_OFFSET:     cfg_q.y_offset     <= cfg_data_i;
        REG_Y_SPAN:       cfg_q.y_span       <= cfg_data_i;
        REG_Y_PIXELS:     cfg_q.y_pixels     <= cfg_data_i[PIXEL_W-1:0];
        REG_SPREAD_LIMIT: cfg_q.spread_limit <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  tsfs_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .push_i         (push_i),
    .full_o         (full_o),
    .x_sample_a_i   (x_sample_a_i),
    .x_sample_b_i   (x_sample_b_i),
    .x_sample_c_i   (x_sample_c_i),
    .x_sample_d_i   (x_sample_d_i),
    .y_sample_a_i   (y_sample_a_i),
    .y_sample_b_i   (y_sample_b_i),
    .y_sample_c_i   (y_sample_c_i),
    .y_sample_d_i   (y_sample_d_i),
    .pen_released_i (pen_released_i),
    .q_push_o       (q_push),
    .q_entry_o      (q_entry_in),
    .q_full_i       (q_full)
  );

  tsfs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_entry_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .entry_o (q_entry_out)
  );

  tsfs_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .q_valid_i     (q_valid),
    .q_entry_i     (q_entry_out),
    .q_pop_o       (q_pop),
    .empty_o       (empty_o),
    .pop_i         (pop_i),
    .event_kind_o  (event_kind_o),
    .x_pos_o       (x_pos_o),
    .y_pos_o       (y_pos_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

>>> design/tsfs_checker.sv
// ----------------------------------------------------------------------------
// tsfs_checker
// Port-level checks of the touch sample filter and scaler result stream.
// ----------------------------------------------------------------------------
module tsfs_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           empty_o,
  input logic                           pop_i,
  input logic [tsfs_pkg::EVENT_W-1:0]   event_kind_o,
  input logic [tsfs_pkg::PIXEL_W-1:0]   x_pos_o,
  input logic [tsfs_pkg::PIXEL_W-1:0]   y_pos_o,
  input logic                           last_of_run_o
);
  import tsfs_pkg::*;

  // a stalled result stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !pop_i) |=> (!empty_o && $stable(event_kind_o) &&
      $stable(x_pos_o) && $stable(y_pos_o) && $stable(last_of_run_o)))
    else $error("stalled result changed");

  // only the touch-up of a release is not the last of its run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> (last_of_run_o == (event_kind_o != EV_UP)))
    else $error("last_of_run does not match event kind");

  // a taken touch-up is followed at once by a touch with the same coordinates
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && pop_i && event_kind_o == EV_UP) |=>
      (!empty_o && event_kind_o == EV_TOUCH &&
       x_pos_o == $past(x_pos_o) && y_pos_o == $past(y_pos_o)))
    else $error("touch-up not followed by matching touch");

  // nothing waits right after reset
  assert property (@(posedge clk_i) $rose(rst_ni) |-> empty_o)
    else $error("result present after reset");

endmodule

bind touch_sample_filter_scaler tsfs_checker u_tsfs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .empty_o       (empty_o),
  .pop_i         (pop_i),
  .event_kind_o  (event_kind_o),
  .x_pos_o       (x_pos_o),
  .y_pos_o       (y_pos_o),
  .last_of_run_o (last_of_run_o)
);

>>> sim/touch_sample_filter_scaler_checker.sv
// ----------------------------------------------------------------------------
// touch_sample_filter_scaler_checker
// Watches the configuration, touch and event channels of the touch sample
// filter and scaler, predicts the events of every accepted touch and compares
// them field by field with the events that the block hands out.
// ----------------------------------------------------------------------------
module touch_sample_filter_scaler_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic                                cfg_ready_i,
  input  logic [tsfs_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [tsfs_pkg::CFG_DAT_W-1:0]      cfg_data_i,
  input  logic                                push_i,
  input  logic                                full_i,
  input  logic [3:0][tsfs_pkg::SAMPLE_W-1:0]  x_samples_i,
  input  logic [3:0][tsfs_pkg::SAMPLE_W-1:0]  y_samples_i,
  input  logic                                pen_released_i,
  input  logic                                empty_i,
  input  logic                                pop_i,
  input  logic [tsfs_pkg::EVENT_W-1:0]        event_kind_i,
  input  logic [tsfs_pkg::PIXEL_W-1:0]        x_pos_i,
  input  logic [tsfs_pkg::PIXEL_W-1:0]        y_pos_i,
  input  logic                                last_of_run_i,
  output int unsigned                         mismatch_count_o = 0,
  output int unsigned                         events_due_o = 0
);

  import tsfs_pkg::*;

  typedef struct packed {
    event_kind_e        kind;
    logic [PIXEL_W-1:0] x_pos;
    logic [PIXEL_W-1:0] y_pos;
    logic               last_of_run;
  } touch_event_t;

  touch_event_t       due_events[$];
  cfg_t               regs;
  logic [PIXEL_W-1:0] held_x;
  logic [PIXEL_W-1:0] held_y;
  int unsigned        mismatches = 0;

  function automatic void flag_mismatch(input string what, input logic [15:0] want,
                                        input logic [15:0] got);
    mismatches++;
    $display("%0t %s: expected %0d actual %0d", $time, what, want, got);
  endfunction

  // second largest and second smallest of the four samples
  function automatic void middle_pair(input logic [3:0][SAMPLE_W-1:0] s,
                                      output logic [SAMPLE_W-1:0] hi,
                                      output logic [SAMPLE_W-1:0] lo);
    logic [SAMPLE_W-1:0] v [4];
    logic [SAMPLE_W-1:0] t;
    for (int i = 0; i < 4; i++) v[i] = s[i];
    for (int i = 0; i < 4; i++) begin
      for (int j = i + 1; j < 4; j++) begin
        if (v[j] > v[i]) begin
          t    = v[i];
          v[i] = v[j];
          v[j] = t;
        end
      end
    end
    hi = v[1];
    lo = v[2];
  endfunction

  function automatic bit scale_axis(input logic [SAMPLE_W-1:0] avg,
                                    input logic [SAMPLE_W-1:0] offset,
                                    input logic [SAMPLE_W-1:0] span,
                                    input logic [PIXEL_W-1:0]  pixels,
                                    output logic [PIXEL_W-1:0] pos);
    logic [63:0] q;
    pos = '0;
    if (span == '0 || avg < offset) return 1'b0;
    q = 64'(avg - offset) * 64'(pixels) / 64'(span);
    if (q == '0 || q > 64'(pixels)) return 1'b0;
    pos = q[PIXEL_W-1:0];
    return 1'b1;
  endfunction

  function automatic void queue_touch_events(input logic [3:0][SAMPLE_W-1:0] xs,
                                             input logic [3:0][SAMPLE_W-1:0] ys,
                                             input logic released);
    logic [SAMPLE_W-1:0] hi;
    logic [SAMPLE_W-1:0] lo;
    logic [SAMPLE_W:0]   pair_sum;
    logic [PIXEL_W-1:0]  pos;
    touch_event_t        ev;
    middle_pair(xs, hi, lo);
    pair_sum = hi + lo;
    // x is dropped when the middle samples are too far apart
    if (hi - lo <= regs.spread_limit) begin
      if (scale_axis(pair_sum[SAMPLE_W:1], regs.x_offset, regs.x_span, regs.x_pixels, pos))
        held_x = pos;
    end
    middle_pair(ys, hi, lo);
    pair_sum = hi + lo;
    if (scale_axis(pair_sum[SAMPLE_W:1], regs.y_offset, regs.y_span, regs.y_pixels, pos))
      held_y = pos;
    ev.x_pos = held_x;
    ev.y_pos = held_y;
    if (released) begin
      ev.kind        = EV_UP;
      ev.last_of_run = 1'b0;
      due_events.push_back(ev);
      ev.kind        = EV_TOUCH;
      ev.last_of_run = 1'b1;
      due_events.push_back(ev);
    end else begin
      ev.kind        = EV_DOWN;
      ev.last_of_run = 1'b1;
      due_events.push_back(ev);
    end
  endfunction

  function automatic void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DAT_W-1:0] data);
    case (cfg_reg_e'(idx))
      REG_X_OFFSET:     regs.x_offset     = data;
      REG_X_SPAN:       regs.x_span       = data;
      REG_X_PIXELS:     regs.x_pixels     = data[PIXEL_W-1:0];
      REG_Y_OFFSET:     regs.y_offset     = data;
      REG_Y_SPAN:       regs.y_span       = data;
      REG_Y_PIXELS:     regs.y_pixels     = data[PIXEL_W-1:0];
      REG_SPREAD_LIMIT: regs.spread_limit = data;
      default: ;
    endcase
  endfunction

  function automatic void check_event();
    touch_event_t want;
    if (due_events.size() == 0) begin
      flag_mismatch("event with nothing due, event_kind", 'x, event_kind_i);
    end else begin
      want = due_events.pop_front();
      if (event_kind_i !== want.kind)
        flag_mismatch("event_kind", want.kind, event_kind_i);
      if (x_pos_i !== want.x_pos)
        flag_mismatch("x_pos", want.x_pos, x_pos_i);
      if (y_pos_i !== want.y_pos)
        flag_mismatch("y_pos", want.y_pos, y_pos_i);
      if (last_of_run_i !== want.last_of_run)
        flag_mismatch("last_of_run", want.last_of_run, last_of_run_i);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs.x_offset     = X_OFFSET_RST;
      regs.x_span       = X_SPAN_RST;
      regs.x_pixels     = X_PIXELS_RST;
      regs.y_offset     = Y_OFFSET_RST;
      regs.y_span       = Y_SPAN_RST;
      regs.y_pixels     = Y_PIXELS_RST;
      regs.spread_limit = SPREAD_LIMIT_RST;
      held_x            = '0;
      held_y            = '0;
      due_events.delete();
      events_due_o     <= 0;
      mismatch_count_o <= mismatches;
    end else begin
      // older events first, then the transaction taken at this edge
      if (pop_i && !empty_i) check_event();
      if (cfg_valid_i && cfg_ready_i) write_reg(cfg_index_i, cfg_data_i);
      if (push_i && !full_i) queue_touch_events(x_samples_i, y_samples_i, pen_released_i);
      events_due_o     <= due_events.size();
      mismatch_count_o <= mismatches;
    end
  end

endmodule

>>> sim/tb_touch_sample_filter_scaler.sv
// ----------------------------------------------------------------------------
// tb_touch_sample_filter_scaler
// Drives touch events and register writes into the touch sample filter and
// scaler: a directed set of edge cases at reset settings, then random touches
// under several calibrations with random idling on both sides and one long
// receiver stall. The checker beside the block predicts and compares events.
// ----------------------------------------------------------------------------
module tb_touch_sample_filter_scaler;

  import tsfs_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int unsigned SETTLE_CYCLES   = 60;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned ITEMS_PER_PHASE = 90;

  typedef struct packed {
    logic [3:0][SAMPLE_W-1:0] xs;
    logic [3:0][SAMPLE_W-1:0] ys;
    logic                     released;
  } touch_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;
  logic                 push;
  logic                 full;
  logic [SAMPLE_W-1:0]  x_sample_a, x_sample_b, x_sample_c, x_sample_d;
  logic [SAMPLE_W-1:0]  y_sample_a, y_sample_b, y_sample_c, y_sample_d;
  logic                 pen_released;
  logic                 empty;
  logic                 pop;
  logic [EVENT_W-1:0]   event_kind;
  logic [PIXEL_W-1:0]   x_pos;
  logic [PIXEL_W-1:0]   y_pos;
  logic                 last_of_run;

  int unsigned mismatches;
  int unsigned events_due;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_left;
  cfg_t        cur_cfg;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  touch_sample_filter_scaler i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .push_i         (push),
    .full_o         (full),
    .x_sample_a_i   (x_sample_a),
    .x_sample_b_i   (x_sample_b),
    .x_sample_c_i   (x_sample_c),
    .x_sample_d_i   (x_sample_d),
    .y_sample_a_i   (y_sample_a),
    .y_sample_b_i   (y_sample_b),
    .y_sample_c_i   (y_sample_c),
    .y_sample_d_i   (y_sample_d),
    .pen_released_i (pen_released),
    .empty_o        (empty),
    .pop_i          (pop),
    .event_kind_o   (event_kind),
    .x_pos_o        (x_pos),
    .y_pos_o        (y_pos),
    .last_of_run_o  (last_of_run)
  );

  touch_sample_filter_scaler_checker i_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .push_i           (push),
    .full_i           (full),
    .x_samples_i      ({x_sample_d, x_sample_c, x_sample_b, x_sample_a}),
    .y_samples_i      ({y_sample_d, y_sample_c, y_sample_b, y_sample_a}),
    .pen_released_i   (pen_released),
    .empty_i          (empty),
    .pop_i            (pop),
    .event_kind_i     (event_kind),
    .x_pos_i          (x_pos),
    .y_pos_i          (y_pos),
    .last_of_run_i    (last_of_run),
    .mismatch_count_o (mismatches),
    .events_due_o     (events_due)
  );

  function automatic touch_t mk_touch(input int xa, input int xb, input int xc, input int xd,
                                      input int ya, input int yb, input int yc, input int yd,
                                      input bit released);
    touch_t t;
    t.xs       = {SAMPLE_W'(xd), SAMPLE_W'(xc), SAMPLE_W'(xb), SAMPLE_W'(xa)};
    t.ys       = {SAMPLE_W'(yd), SAMPLE_W'(yc), SAMPLE_W'(yb), SAMPLE_W'(ya)};
    t.released = released;
    return t;
  endfunction

  // four samples around a centre, sometimes with one wild outlier
  function automatic logic [3:0][SAMPLE_W-1:0] jittered_axis(input int centre, input int jit);
    logic [3:0][SAMPLE_W-1:0] s;
    int                       v;
    for (int i = 0; i < 4; i++) begin
      v = centre + int'($urandom_range(0, 2 * jit)) - jit;
      if (v < 0) v = 0;
      if (v > 8191) v = 8191;
      s[i] = SAMPLE_W'(v);
    end
    if ($urandom_range(0, 2) == 0) s[$urandom_range(0, 3)] = SAMPLE_W'($urandom);
    return s;
  endfunction

  function automatic touch_t random_touch();
    touch_t t;
    int     jit;
    t.released = $urandom_range(0, 1);
    if ($urandom_range(0, 99) < 25) begin
      for (int i = 0; i < 4; i++) begin
        t.xs[i] = SAMPLE_W'($urandom);
        t.ys[i] = SAMPLE_W'($urandom);
      end
    end else begin
      jit  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 400) : $urandom_range(0, 16);
      t.xs = jittered_axis(int'(cur_cfg.x_offset) + int'($urandom_range(0, cur_cfg.x_span)),
                           jit);
      jit  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 400) : $urandom_range(0, 16);
      t.ys = jittered_axis(int'(cur_cfg.y_offset) + int'($urandom_range(0, cur_cfg.y_span)),
                           jit);
    end
    return t;
  endfunction

  // entered and left at a falling edge; push stays high for a following touch
  task automatic send_touch(input touch_t t);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    x_sample_a   <= t.xs[0];
    x_sample_b   <= t.xs[1];
    x_sample_c   <= t.xs[2];
    x_sample_d   <= t.xs[3];
    y_sample_a   <= t.ys[0];
    y_sample_b   <= t.ys[1];
    y_sample_c   <= t.ys[2];
    y_sample_d   <= t.ys[3];
    pen_released <= t.released;
    push         <= 1'b1;
    do @(posedge clk); while (full);
    @(negedge clk);
  endtask

  task automatic run_random(input int unsigned count);
    repeat (count) send_touch(random_touch());
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // pixel counts go out with junk in the bits above the register width
  task automatic apply_setting(input cfg_t s, input logic [2:0] pixel_junk);
    write_reg(REG_X_OFFSET, s.x_offset);
    write_reg(REG_X_SPAN, s.x_span);
    write_reg(REG_X_PIXELS, {pixel_junk, s.x_pixels});
    write_reg(REG_Y_OFFSET, s.y_offset);
    write_reg(REG_Y_SPAN, s.y_span);
    write_reg(REG_Y_PIXELS, {pixel_junk, s.y_pixels});
    write_reg(REG_SPREAD_LIMIT, s.spread_limit);
    write_reg(REG_UNUSED, CFG_DAT_W'($urandom));
    cfg_valid <= 1'b0;
    cur_cfg = s;
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (events_due != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct <= recv_pct;
  endtask

  // receiver: random pops, or a counted hold-off when one is asked for
  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left = hold_left - 1;
      end else begin
        pop <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    #4_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    rst_n         = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    push          = 1'b0;
    x_sample_a    = '0;
    x_sample_b    = '0;
    x_sample_c    = '0;
    x_sample_d    = '0;
    y_sample_a    = '0;
    y_sample_b    = '0;
    y_sample_c    = '0;
    y_sample_d    = '0;
    pen_released  = 1'b0;
    hold_left     = 0;
    send_idle_pct = 29;
    recv_idle_pct = 76;
    cur_cfg = '{x_offset: X_OFFSET_RST, x_span: X_SPAN_RST, x_pixels: X_PIXELS_RST,
                y_offset: Y_OFFSET_RST, y_span: Y_SPAN_RST, y_pixels: Y_PIXELS_RST,
                spread_limit: SPREAD_LIMIT_RST};
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // edge cases at reset calibration
    send_touch(mk_touch(0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
    send_touch(mk_touch(8191, 8191, 8191, 8191, 8191, 8191, 8191, 8191, 1'b1));
    send_touch(mk_touch(2000, 2000, 2000, 2000, 2000, 2000, 2000, 2000, 1'b0));
    send_touch(mk_touch(2600, 2600, 2600, 2600, 1500, 1500, 1500, 1500, 1'b1));
    send_touch(mk_touch(1000, 1100, 1000, 1100, 3000, 3000, 3000, 3000, 1'b0));
    send_touch(mk_touch(1025, 1000, 1025, 1000, 2500, 2500, 2500, 2500, 1'b0));
    send_touch(mk_touch(0, 8191, 1500, 1510, 8191, 0, 2500, 2490, 1'b1));
    send_touch(mk_touch(200, 200, 200, 200, 190, 190, 190, 190, 1'b0));
    send_touch(mk_touch(4000, 4000, 4000, 4000, 4000, 4000, 4000, 4000, 1'b0));
    send_touch(mk_touch(4016, 4016, 4016, 4016, 4012, 4012, 4012, 4012, 1'b1));
    send_touch(mk_touch(199, 199, 199, 199, 189, 189, 189, 189, 1'b0));
    send_touch(mk_touch(216, 216, 216, 216, 202, 202, 202, 202, 1'b0));
    send_touch(mk_touch(215, 215, 215, 215, 201, 201, 201, 201, 1'b1));
    send_touch(mk_touch(1001, 1002, 1001, 1002, 701, 702, 702, 701, 1'b0));
    send_touch(mk_touch(3000, 2990, 2980, 2970, 100, 200, 300, 400, 1'b1));
    send_touch(mk_touch(5461, 2730, 5461, 2730, 2730, 5461, 2730, 5461, 1'b0));
    wait_drained();

    // widest calibration
    apply_setting('{x_offset: 13'd0, x_span: 13'd8191, x_pixels: 10'd1023,
                    y_offset: 13'd0, y_span: 13'd8191, y_pixels: 10'd1023,
                    spread_limit: 13'd8191}, 3'b000);
    run_random(ITEMS_PER_PHASE);
    wait_drained();

    // narrowest calibration, zero spread allowed
    apply_setting('{x_offset: 13'd4000, x_span: 13'd1, x_pixels: 10'd1,
                    y_offset: 13'd8191, y_span: 13'd1, y_pixels: 10'd1023,
                    spread_limit: 13'd0}, 3'b111);
    run_random(ITEMS_PER_PHASE);
    wait_drained();

    set_idling(76, 29);
    // zero x span and zero y pixel count
    apply_setting('{x_offset: 13'd200, x_span: 13'd0, x_pixels: 10'd240,
                    y_offset: 13'd190, y_span: 13'd3810, y_pixels: 10'd0,
                    spread_limit: 13'd25}, 3'b101);
    run_random(ITEMS_PER_PHASE);
    wait_drained();

    apply_setting('{x_offset: SAMPLE_W'($urandom_range(0, 1500)),
                    x_span: SAMPLE_W'($urandom_range(1, 8191)),
                    x_pixels: PIXEL_W'($urandom_range(1, 1023)),
                    y_offset: SAMPLE_W'($urandom_range(0, 1500)),
                    y_span: SAMPLE_W'($urandom_range(1, 8191)),
                    y_pixels: PIXEL_W'($urandom_range(1, 1023)),
                    spread_limit: SAMPLE_W'($urandom_range(0, 60))}, 3'($urandom));
    run_random(ITEMS_PER_PHASE);
    wait_drained();

    set_idling(0, 0);
    apply_setting('{x_offset: X_OFFSET_RST, x_span: X_SPAN_RST, x_pixels: X_PIXELS_RST,
                    y_offset: Y_OFFSET_RST, y_span: Y_SPAN_RST, y_pixels: Y_PIXELS_RST,
                    spread_limit: SPREAD_LIMIT_RST}, 3'b000);
    run_random(ITEMS_PER_PHASE / 2);
    // receiver stalls long enough for the block to fill and push back
    hold_left <= HOLD_OFF_CYCLES;
    run_random(12);
    run_random(ITEMS_PER_PHASE / 2);
    wait_drained();

    if (mismatches == 0 && events_due == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
design/tsfs_pkg.sv
design/tsfs_front.sv
design/tsfs_queue.sv
design/tsfs_back.sv
design/touch_sample_filter_scaler.sv
design/tsfs_checker.sv
sim/touch_sample_filter_scaler_checker.sv
sim/tb_touch_sample_filter_scaler.sv
